[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Simulation builds get concurrent
// assertions. Synthesis builds define SYNTHESIS, and then every macro expands
// to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When the antecedent holds at an edge, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// When the antecedent holds at an edge, the consequent must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/pbu_pkg.sv]
package pbu_pkg;

  localparam logic [7:0] CHANNEL_MAX = 8'd255;
  localparam int NUM_CHAN = 3;

  // Register indexes of the write port.
  localparam logic [1:0] REG_BLEND_MODE   = 2'd0;
  localparam logic [1:0] REG_GREEN_OFFSET = 2'd1;
  localparam logic [1:0] REG_RED_GAIN     = 2'd2;

  // Blend mode codes. Codes above MODE_GREY_B pass the top pixel through.
  localparam logic [3:0] MODE_MUL       = 4'd0;
  localparam logic [3:0] MODE_SUB       = 4'd1;
  localparam logic [3:0] MODE_SCREEN    = 4'd2;
  localparam logic [3:0] MODE_OVERLAY   = 4'd3;
  localparam logic [3:0] MODE_ADD_GREEN = 4'd4;
  localparam logic [3:0] MODE_RED_GAIN  = 4'd5;
  localparam logic [3:0] MODE_GREY_R    = 4'd6;
  localparam logic [3:0] MODE_GREY_G    = 4'd7;
  localparam logic [3:0] MODE_GREY_B    = 4'd8;

  // One incoming request: the top layer pixel and the bottom layer pixel.
  typedef struct packed {
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] bottom_red;
    logic [7:0] bottom_green;
    logic [7:0] bottom_blue;
  } pixel_pair_t;

  // One blended pixel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pixel_out_t;

  typedef struct packed {
    logic [3:0]        blend_mode;
    logic signed [8:0] green_offset;
    logic [3:0]        red_gain;
  } blend_cfg_t;

  // The kind of work left for a channel after the front stage.
  typedef enum logic [2:0] {
    KIND_DIRECT,
    KIND_MUL,
    KIND_SCREEN,
    KIND_OVL_LOW,
    KIND_OVL_HIGH
  } chan_kind_t;

  typedef struct packed {
    chan_kind_t kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] direct;
  } chan_work_t;

endpackage

[rtl/core/pbu_prep.sv]
module pbu_prep import pbu_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  pixel_pair_t                 pair,
  input  blend_cfg_t                  cfg,
  output chan_work_t [NUM_CHAN-1:0]   work
);

  localparam logic [7:0] CHANNEL_HALF = CHANNEL_MAX >> 1;

  logic [NUM_CHAN-1:0][7:0]  ta;
  logic [NUM_CHAN-1:0][7:0]  tb;
  logic signed [10:0]        green_sum;
  logic [11:0]               red_prod;
  logic [7:0]                green_sat;
  logic [7:0]                red_sat;
  logic [7:0]                grey;
  chan_work_t [NUM_CHAN-1:0] work_next;

  assign ta = {pair.top_blue, pair.top_green, pair.top_red};
  assign tb = {pair.bottom_blue, pair.bottom_green, pair.bottom_red};

  always_comb begin
    green_sum = $signed({3'b000, ta[1]})
              + $signed({{2{cfg.green_offset[8]}}, cfg.green_offset});
    if (green_sum < 11'sd0) begin
      green_sat = 8'd0;
    end else if (green_sum > $signed({3'b000, CHANNEL_MAX})) begin
      green_sat = CHANNEL_MAX;
    end else begin
      green_sat = green_sum[7:0];
    end

    red_prod = 12'(ta[0]) * 12'(cfg.red_gain);
    red_sat  = (|red_prod[11:8]) ? CHANNEL_MAX : red_prod[7:0];

    case (cfg.blend_mode)
      MODE_GREY_R: grey = ta[0];
      MODE_GREY_G: grey = ta[1];
      default:     grey = ta[2];
    endcase

    for (int i = 0; i < NUM_CHAN; i++) begin
      work_next[i].kind   = KIND_DIRECT;
      work_next[i].x      = ta[i];
      work_next[i].y      = tb[i];
      work_next[i].direct = ta[i];
      case (cfg.blend_mode)
        MODE_MUL: begin
          work_next[i].kind = KIND_MUL;
        end
        MODE_SUB: begin
          work_next[i].direct = (ta[i] > tb[i]) ? ta[i] - tb[i] : 8'd0;
        end
        MODE_SCREEN: begin
          work_next[i].kind = KIND_SCREEN;
          work_next[i].x    = CHANNEL_MAX - ta[i];
          work_next[i].y    = CHANNEL_MAX - tb[i];
        end
        MODE_OVERLAY: begin
          if (tb[i] <= CHANNEL_HALF) begin
            work_next[i].kind = KIND_OVL_LOW;
          end else begin
            work_next[i].kind = KIND_OVL_HIGH;
            work_next[i].x    = CHANNEL_MAX - ta[i];
            work_next[i].y    = CHANNEL_MAX - tb[i];
          end
        end
        MODE_ADD_GREEN: begin
          if (i == 1) begin
            work_next[i].direct = green_sat;
          end
        end
        MODE_RED_GAIN: begin
          if (i == 0) begin
            work_next[i].direct = red_sat;
          end else if (i == 2) begin
            work_next[i].direct = 8'd0;
          end
        end
        MODE_GREY_R, MODE_GREY_G, MODE_GREY_B: begin
          work_next[i].direct = grey;
        end
        default: begin
          // Undefined modes pass the top pixel through.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work <= work_next;
    end
  end

endmodule

[rtl/core/pbu_chan.sv]
module pbu_chan import pbu_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  chan_work_t work,
  output logic [7:0] result
);

  localparam logic [16:0] SQ_MAX    = 17'(CHANNEL_MAX) * 17'(CHANNEL_MAX);
  localparam logic [16:0] ROUND_ADD = 17'(CHANNEL_MAX >> 1);

  // Product stage.
  logic [15:0] prod;
  chan_kind_t  kind2;
  logic [7:0]  direct2;

  // Scaling stage: rounded numerator and a quotient estimate that is low by
  // at most one.
  logic [16:0] num;
  logic [16:0] num_rnd;
  logic [23:0] scaled;
  logic [16:0] num3;
  logic [7:0]  quot3;
  chan_kind_t  kind3;
  logic [7:0]  direct3;

  // Correction stage.
  logic [16:0] rem;
  logic [7:0]  quot;
  logic [7:0]  result_next;

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= 16'(work.x) * 16'(work.y);
      kind2   <= work.kind;
      direct2 <= work.direct;
    end
  end

  always_comb begin
    case (kind2)
      KIND_OVL_LOW:  num = {prod, 1'b0};
      KIND_OVL_HIGH: num = SQ_MAX - {prod, 1'b0};
      default:       num = {1'b0, prod};
    endcase
    // Rounding to nearest is floor((n + 127) / 255); the odd divisor rules out ties.
    num_rnd = num + ROUND_ADD;
    // The factor 257 / 65536 sits just below 1 / 255.
    scaled  = 24'({num_rnd, 8'h00}) + 24'(num_rnd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3    <= num_rnd;
      quot3   <= scaled[23:16];
      kind3   <= kind2;
      direct3 <= direct2;
    end
  end

  always_comb begin
    rem  = num3 - 17'(quot3) * 17'(CHANNEL_MAX);
    quot = quot3 + 8'(rem >= 17'(CHANNEL_MAX));
    case (kind3)
      KIND_DIRECT: result_next = direct3;
      KIND_SCREEN: result_next = CHANNEL_MAX - quot;
      default:     result_next = quot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

[rtl/core/pixel_blend_unit.sv]
// RGB888 layer blender, one top pixel and one bottom pixel in, one blended
// pixel out.
// The pair channel (pair_valid, pair_stall, pair) carries requests in, and the
// result channel (result_valid, result_stall, result) carries blended pixels out.
// A request is taken at a rising edge with valid high and stall low.
// The write port (cfg_write, cfg_index, cfg_data) sets blend_mode (index 0),
// green_offset (index 1) and red_gain (index 2). Write it only while the block
// holds no requests.
// A request taken at one edge passes through the four register stages in
// order: operand preparation, an 8x8 product per channel, rounded scaling by
// 1/255, and a correction step that feeds the output register, where it shows
// up with result_valid high. Throughput is one pixel per clock while the output
// is not stalled, since each stage then takes a new request every cycle.
// When result_stall is high with a result waiting, every stage holds and
// pair_stall goes high in the same cycle, so nothing is lost or repeated.
// Synchronous reset clears all stage valid bits and loads the register
// defaults: multiply mode, zero green offset, red gain of four.
`include "assert_macros.svh"

module pixel_blend_unit import pbu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pair_valid,
  output logic        pair_stall,
  input  pixel_pair_t pair,
  output logic        result_valid,
  input  logic        result_stall,
  output pixel_out_t  result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam logic [3:0] RESET_BLEND_MODE = 4'd0;
  localparam logic [3:0] RESET_RED_GAIN   = 4'd4;

  blend_cfg_t                cfg;
  logic                      advance;
  logic [2:0]                stage_valid;
  chan_work_t [NUM_CHAN-1:0] work;
  logic [NUM_CHAN-1:0][7:0]  chan_out;

  // Configuration registers. The write port has no handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_mode   <= RESET_BLEND_MODE;
      cfg.green_offset <= '0;
      cfg.red_gain     <= RESET_RED_GAIN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLEND_MODE:   cfg.blend_mode   <= cfg_data[3:0];
        REG_GREEN_OFFSET: cfg.green_offset <= cfg_data;
        REG_RED_GAIN:     cfg.red_gain     <= cfg_data[3:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // The whole pipeline moves together. It holds only when the output register
  // has a result that the receiver is not taking.
  assign advance    = !(result_valid && result_stall);
  assign pair_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      stage_valid  <= {stage_valid[1:0], pair_valid};
      result_valid <= stage_valid[2];
    end
  end

  // Front stage: mode decoding, the single-pixel modes and operand selection.
  pbu_prep u_prep (
    .clk  (clk),
    .en   (advance),
    .pair (pair),
    .cfg  (cfg),
    .work (work)
  );

  // Per-channel product, rounded scaling and output register.
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    pbu_chan u_chan (
      .clk    (clk),
      .en     (advance),
      .work   (work[c]),
      .result (chan_out[c])
    );
  end

  assign result.out_red   = chan_out[0];
  assign result.out_green = chan_out[1];
  assign result.out_blue  = chan_out[2];

  // An accepted request must occupy the first stage at the next edge.
  `ASSERT_NEXT(a_accept_fills_stage1, clk, rst, pair_valid && !pair_stall, stage_valid[0])
  // A request leaving the last inner stage must land in the output register.
  `ASSERT_NEXT(a_stage3_to_result, clk, rst, stage_valid[2] && advance, result_valid)
  // While the pipeline is held, no stage may gain or lose a request.
  `ASSERT_NEXT(a_hold_keeps_stages, clk, rst, !advance, $stable(stage_valid) && result_valid)
  // The input side may be held only when a waiting result is being refused.
  `ASSERT_IMPLIES(a_stall_matches_hold, clk, rst, pair_stall, result_valid && result_stall)

endmodule
